// ===== design/msscan_pkg.sv =====
// msscan_pkg: shared constants, register codes, types and helpers
// for the masked byte signature scan; no dependencies
package msscan_pkg;

    localparam int MaxPattern = 32;
    localparam int OffsetBits = 32;
    localparam int ByteW      = 8;
    localparam int LenW       = 6;
    localparam int PatIdxW    = 5;
    localparam int IdxW       = 3;
    localparam int CfgW       = 64;
    localparam int PatWords   = 4;
    localparam int CareW      = 32;
    localparam int OffW       = 32;

    // register indexes on the configuration port
    localparam logic [IdxW-1:0] REG_PAT0 = 3'd0;
    localparam logic [IdxW-1:0] REG_PAT1 = 3'd1;
    localparam logic [IdxW-1:0] REG_PAT2 = 3'd2;
    localparam logic [IdxW-1:0] REG_PAT3 = 3'd3;
    localparam logic [IdxW-1:0] REG_CARE = 3'd4;
    localparam logic [IdxW-1:0] REG_LEN  = 3'd5;

    typedef logic [LenW-1:0]       len_t;
    typedef logic [OffsetBits-1:0] count_t;

    typedef struct packed {
        logic [PatWords*CfgW-1:0] pattern;
        logic [CareW-1:0]         care;
        len_t                     eff_len;
    } cfg_t;

    // zero acts as one, anything above the cell count as the cell count
    function automatic len_t eff_length(input len_t raw);
        len_t len;
        len = raw;
        if (raw == '0)
            len = len_t'(1);
        else if (raw > len_t'(MaxPattern))
            len = len_t'(MaxPattern);
        return len;
    endfunction

endpackage

// ===== design/msscan_if.sv =====
// msscan channel interfaces: input byte words, result words, config writes
// depends on msscan_pkg
interface msscan_byte_if;
    logic                        valid;
    logic                        ready;
    logic [msscan_pkg::ByteW-1:0] scan_byte;
    logic                        last_byte;

    modport source (output valid, scan_byte, last_byte, input ready);
    modport sink   (input valid, scan_byte, last_byte, output ready);
endinterface

interface msscan_res_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [msscan_pkg::OffW-1:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

interface msscan_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [msscan_pkg::IdxW-1:0] index;
    logic [msscan_pkg::CfgW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/masked_byte_signature_scan.sv =====
// masked_byte_signature_scan: top level of the wildcard byte pattern search
// depends on msscan_pkg, msscan_if, msscan_cfg_regs and msscan_cell
//
//  channel    dir  payload                     accepted when
//  byte_in    in   scan_byte, last_byte        byte_in.valid & byte_in.ready
//  result     out  found, match_offset         result.valid & result.ready
//  cfg        in   index, data                 cfg.valid & cfg.ready (always ready)
//
// one byte word per cycle; the verdict for a byte is registered on the cycle
// it is taken, so a result is valid in the cycle after its byte
// the rate is set by the row of 32 byte cells, which shift and compare together
// byte_in stalls only while a result waits and result.ready is low
// reset clears the byte count, the reported flag and the output valid; the
// config registers return to pattern zero, care all ones, length one
module masked_byte_signature_scan (
    input  logic        clk,
    input  logic        rst_n,
    msscan_byte_if.sink byte_in,
    msscan_res_if.source result,
    msscan_cfg_if.sink  cfg
);
    import msscan_pkg::*;

    cfg_t             cfg_q;
    logic             in_acc;

    // window row
    logic [ByteW-1:0] cell_q   [MaxPattern];
    logic [ByteW-1:0] cell_d   [MaxPattern];
    logic [MaxPattern-1:0] hit;

    // scan state
    count_t           seen_reg, seen_next, seen_inc;
    logic             reported_reg, reported_next;
    logic             enough, match, miss_end, res_load;
    count_t           offset;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic             found_reg;
    logic [OffW-1:0]  offset_reg;

    msscan_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    // take a byte whenever the result register is free or being emptied
    assign byte_in.ready = !out_valid_reg || result.ready;
    assign in_acc        = byte_in.valid && byte_in.ready;

    // cell j compares the byte j places back; it lines up with pattern byte
    // len-1-j, and cells at or beyond the length take no part
    for (genvar j = 0; j < MaxPattern; j++)
    begin : g_cell
        localparam len_t CellIdx = len_t'(j);
        len_t        pat_k;
        logic        act;

        assign pat_k = cfg_q.eff_len - CellIdx - len_t'(1);
        assign act   = CellIdx < cfg_q.eff_len;

        if (j == 0)
        begin : g_head
            assign cell_d[j] = byte_in.scan_byte;
        end
        else
        begin : g_body
            assign cell_d[j] = cell_q[j-1];
        end

        msscan_cell u_cell (
            .clk      (clk),
            .shift_en (in_acc),
            .d_in     (cell_d[j]),
            .want     (cfg_q.pattern[pat_k[PatIdxW-1:0]*ByteW +: ByteW]),
            .care     (cfg_q.care[pat_k[PatIdxW-1:0]]),
            .active   (act),
            .q        (cell_q[j]),
            .hit      (hit[j])
        );
    end

    // byte count saturates at all ones
    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + count_t'(1);
    assign enough   = seen_inc >= count_t'(cfg_q.eff_len);
    assign match    = !reported_reg && enough && (&hit);
    assign miss_end = !reported_reg && byte_in.last_byte && !match;
    assign res_load = in_acc && (match || miss_end);
    assign offset   = seen_inc - count_t'(cfg_q.eff_len);

    always_comb
    begin
        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (in_acc)
        begin
            if (byte_in.last_byte)
            begin
                // end of region: ready for the next scan
                seen_next     = '0;
                reported_next = 1'b0;
            end
            else
            begin
                seen_next     = seen_inc;
                reported_next = reported_reg || match;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with the verdict word
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            found_reg  <= match;
            offset_reg <= match ? OffW'(offset) : '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = found_reg;
    assign result.match_offset = offset_reg;

    // a not-found word always carries a zero offset
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> offset_reg == '0)
        else $error("not-found result with nonzero offset");

    // the last byte leaves the scan state cleared
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && byte_in.last_byte |=> seen_reg == '0 && !reported_reg)
        else $error("scan state not cleared after last byte");

    // once a match is reported no further word comes from the same scan
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && reported_reg |-> !res_load)
        else $error("second result in one scan");

    // a match never reported before enough bytes were seen
    a_enough_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && match |-> seen_inc >= count_t'(cfg_q.eff_len))
        else $error("match before pattern length reached");

endmodule

// ===== design/msscan_cfg_regs.sv =====
// msscan_cfg_regs: pattern, care mask and length registers
// depends on msscan_pkg and msscan_cfg_if
module msscan_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    msscan_cfg_if.sink         cfg,
    output msscan_pkg::cfg_t   cfg_out
);
    import msscan_pkg::*;

    logic [CfgW-1:0]  pat_reg [PatWords];
    logic [CareW-1:0] care_reg;
    len_t             len_reg;
    logic             wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < PatWords; w++)
            begin
                pat_reg[w] <= '0;
            end
            care_reg <= '1;
            len_reg  <= len_t'(1);
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                REG_PAT0: pat_reg[0] <= cfg.data;
                REG_PAT1: pat_reg[1] <= cfg.data;
                REG_PAT2: pat_reg[2] <= cfg.data;
                REG_PAT3: pat_reg[3] <= cfg.data;
                REG_CARE: care_reg   <= cfg.data[CareW-1:0];
                REG_LEN:  len_reg    <= cfg.data[LenW-1:0];
                default:  ;
            endcase
        end
    end

    assign cfg_out.pattern = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};
    assign cfg_out.care    = care_reg;
    assign cfg_out.eff_len = eff_length(len_reg);

endmodule

// ===== design/msscan_cell.sv =====
// msscan_cell: one window byte stage with its masked compare
// depends on msscan_pkg
module msscan_cell (
    input  logic                         clk,
    input  logic                         shift_en,
    input  logic [msscan_pkg::ByteW-1:0] d_in,
    input  logic [msscan_pkg::ByteW-1:0] want,
    input  logic                         care,
    input  logic                         active,
    output logic [msscan_pkg::ByteW-1:0] q,
    output logic                         hit
);
    import msscan_pkg::*;

    logic [ByteW-1:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= d_in;
        end
    end

    assign q = byte_reg;
    // compare against the byte that enters this stage on the shift
    assign hit = !active || !care || (d_in == want);

endmodule
